@@ hdl/move_to_front_codec_unit_macros.svh @@
// ----------------------------------------------------------------------------
// move_to_front_codec_unit_macros
// assertion shorthands used by the checker file of the codec
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_CODEC_UNIT_MACROS_SVH
`define MOVE_TO_FRONT_CODEC_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define MTFC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mtfc same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge
`define MTFC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mtfc next-cycle check failed");

`endif

@@ hdl/mtfc_pkg.sv @@
// ----------------------------------------------------------------------------
// mtfc_pkg
// shared widths, constants and token type of the move-to-front codec
// ----------------------------------------------------------------------------
package mtfc_pkg;

   // width of one list entry, of a symbol and of a list position
   localparam int SYM_W = 8;

   // default number of symbols in the list
   localparam int ALPHABET_SIZE_DEF = 256;

   // code given for a byte outside the alphabet
   localparam logic [SYM_W-1:0] NO_MATCH_CODE = 8'hFF;

   // token moving along the cell chain
   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] data;
   } mtfc_tok_type;

endpackage

@@ hdl/mtfc_cell.sv @@
// ----------------------------------------------------------------------------
// mtfc_cell
// one list entry; forwards the search token right and the result token left
// ----------------------------------------------------------------------------
module mtfc_cell
   import mtfc_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             decode_mode,
   input  logic             restore,
   input  logic [SYM_W-1:0] key,
   input  logic [SYM_W-1:0] left_entry,
   input  mtfc_tok_type     from_left,
   input  mtfc_tok_type     from_right,
   output logic [SYM_W-1:0] entry,
   output mtfc_tok_type     to_right,
   output mtfc_tok_type     to_left
);

   localparam logic [SYM_W-1:0] IDX = SYM_W'(INDEX);
   localparam bit FRONT = (INDEX == 0);

   logic [SYM_W-1:0] entry_ff, entry_in;
   mtfc_tok_type     to_right_ff, to_right_in;
   mtfc_tok_type     to_left_ff, to_left_in;
   logic             hit;

   // match: own value when encoding, own position when decoding
   assign hit = decode_mode ? (IDX == key) : (entry_ff == key);

   // cell update for the search and return passes
   always_comb begin
      entry_in    = entry_ff;
      to_right_in = '0;
      to_left_in  = '0;
      if (restore) begin
         entry_in = IDX;
      end else if (from_left.valid) begin
         if (!hit) begin
            to_right_in = '{valid: 1'b1, data: entry_ff};
         end else begin
            to_left_in = '{valid: 1'b1, data: (decode_mode ? entry_ff : IDX)};
         end
         if (!decode_mode) begin
            // encode shifts on the way out
            entry_in = from_left.data;
         end else if (hit && !FRONT) begin
            entry_in = left_entry;
         end
      end else if (from_right.valid) begin
         to_left_in = from_right;
         if (decode_mode) begin
            // decode shifts on the way back, front takes the chosen byte
            entry_in = FRONT ? from_right.data : left_entry;
         end
      end
   end

   // cell registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff    <= IDX;
         to_right_ff <= '0;
         to_left_ff  <= '0;
      end else begin
         entry_ff    <= entry_in;
         to_right_ff <= to_right_in;
         to_left_ff  <= to_left_in;
      end
   end

   assign entry    = entry_ff;
   assign to_right = to_right_ff;
   assign to_left  = to_left_ff;

endmodule

@@ hdl/move_to_front_codec_unit.sv @@
// ----------------------------------------------------------------------------
// move_to_front_codec_unit
// byte move-to-front encoder and decoder built on a chain of list cells
// ----------------------------------------------------------------------------
// channel  | direction | tdata         | tuser
// req      | in        | [7:0] symbol  | [0] restart
// rsp      | out       | [7:0] code    | -
// csr      | in        | [0] decode_mode (csr_wdata, written when csr_we)
//
// an item's search token walks right one cell per cycle to the cell that
// matches, and the result token walks back to the front; when encoding, a
// byte outside the alphabet skips the chain and gives NO_MATCH_CODE.
// one item is in the chain at a time; a finished word waits in the output
// register, a second one in a one-deep holding register, and accept stops
// while the holding register is full.
// synchronous reset restores the identity list and empties the chain.
// ----------------------------------------------------------------------------
module move_to_front_codec_unit
   import mtfc_pkg::*;
#(
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request: tdata [7:0] symbol; tuser [0] restart
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [SYM_W-1:0] req_tdata,
   input  logic             req_tuser,
   // response: tdata [7:0] code
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [SYM_W-1:0] rsp_tdata,
   // configuration: csr_wdata [0] decode_mode
   input  logic             csr_we,
   input  logic             csr_wdata
);

   localparam int N = ALPHABET_SIZE;
   localparam logic [SYM_W-1:0] LAST_POS = SYM_W'(ALPHABET_SIZE - 1);
   localparam logic [SYM_W:0]   SIZE_EXT = (SYM_W + 1)'(ALPHABET_SIZE);

   logic             mode_ff, mode_in;
   logic             busy_ff, busy_in;
   logic [SYM_W-1:0] key_ff, key_in;
   mtfc_tok_type     start_ff, start_in;
   logic             direct_ff, direct_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_data_ff, rsp_data_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0] pend_data_ff, pend_data_in;

   logic             accept;
   logic             out_of_range;
   logic             restore;
   logic             done;
   logic [SYM_W-1:0] done_data;
   logic             rsp_free;

   mtfc_tok_type     fwd_tok [N];
   mtfc_tok_type     bwd_tok [N];
   logic [SYM_W-1:0] entry_q [N];

   // input handshake
   assign req_tready   = !busy_ff && !pend_valid_ff;
   assign accept       = req_tvalid && req_tready;
   assign restore      = accept && req_tuser;
   assign out_of_range = !mode_ff && ({1'b0, req_tdata} >= SIZE_EXT);

   // mode register
   assign mode_in = csr_we ? csr_wdata : mode_ff;

   // key capture, position saturates when decoding
   always_comb begin
      key_in    = key_ff;
      start_in  = '0;
      direct_in = 1'b0;
      if (accept) begin
         if (mode_ff && ({1'b0, req_tdata} >= SIZE_EXT)) begin
            key_in = LAST_POS;
         end else begin
            key_in = req_tdata;
         end
         if (out_of_range) begin
            direct_in = 1'b1;
         end else begin
            start_in = '{valid: 1'b1, data: key_in};
         end
      end
   end

   // completion of an item
   assign done      = bwd_tok[0].valid || direct_ff;
   assign done_data = direct_ff ? NO_MATCH_CODE : bwd_tok[0].data;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   // output register and holding register
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      if (pend_valid_ff) begin
         if (rsp_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = pend_data_ff;
            pend_valid_in = 1'b0;
         end
      end else if (done) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = done_data;
         end else begin
            pend_valid_in = 1'b1;
            pend_data_in  = done_data;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         busy_ff       <= 1'b0;
         start_ff      <= '0;
         direct_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         busy_ff       <= busy_in;
         start_ff      <= start_in;
         direct_ff     <= direct_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      rsp_data_ff  <= rsp_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // chain of list cells, position 0 at the front
   for (genvar i = 0; i < N; i++) begin : g_cell
      mtfc_tok_type     left_tok;
      mtfc_tok_type     right_tok;
      logic [SYM_W-1:0] left_val;

      if (i == 0) begin : g_front
         assign left_tok = start_ff;
         assign left_val = entry_q[0];
      end else begin : g_inner
         assign left_tok = fwd_tok[i-1];
         assign left_val = entry_q[i-1];
      end

      if (i == N - 1) begin : g_back
         assign right_tok = '0;
      end else begin : g_link
         assign right_tok = bwd_tok[i+1];
      end

      mtfc_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .decode_mode (mode_ff),
         .restore     (restore),
         .key         (key_ff),
         .left_entry  (left_val),
         .from_left   (left_tok),
         .from_right  (right_tok),
         .entry       (entry_q[i]),
         .to_right    (fwd_tok[i]),
         .to_left     (bwd_tok[i])
      );
   end

endmodule

@@ hdl/mtfc_checker.sv @@
// ----------------------------------------------------------------------------
// mtfc_checker
// port-level checks of the move-to-front codec, bound to the top level
// ----------------------------------------------------------------------------
`include "move_to_front_codec_unit_macros.svh"

module mtfc_checker
   import mtfc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [SYM_W-1:0] rsp_tdata
);

   logic req_word;

   assign req_word = req_tvalid && req_tready;

   // a stalled response word holds
   `MTFC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // the chain takes one word at a time
   `MTFC_ASSERT_NEXT(a_one_in_flight, req_word, !req_tready)

   // no result shows up in the cycle right after a word is taken while the output is empty
   `MTFC_ASSERT_NEXT(a_no_early_rsp, req_word && !rsp_tvalid, !rsp_tvalid)

   // a word is only taken while the block reports ready
   `MTFC_ASSERT_NOW(a_ready_gate, req_tvalid && !req_tready, !req_word)

endmodule

bind move_to_front_codec_unit mtfc_checker u_mtfc_checker (.*);
